// ===== src/gscc_pkg.sv =====
// Shared types and constants for the gear shift and clutch control unit.
// No dependencies; used by gscc_cmp and the top level.
package gscc_pkg;

  // Field widths
  localparam int GEAR_W   = 5;
  localparam int WORD_W   = 16;
  localparam int ANGLE_W  = 15;
  localparam int CLUTCH_W = 17;
  localparam int TOPG_W   = 4;

  // Default shift spacing in control ticks
  localparam int SHIFT_DELAY_DEF = 25;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_REDLINE  = 1'b0,
    REG_TOP_GEAR = 1'b1
  } cfg_reg_t;

  localparam logic [WORD_W-1:0] REDLINE_RESET  = 16'd16000;
  localparam logic [TOPG_W-1:0] TOP_GEAR_RESET = 4'd6;

  // Gear codes
  localparam logic signed [GEAR_W-1:0] GEAR_REV     = -5'sd1;
  localparam logic signed [GEAR_W-1:0] GEAR_NEUTRAL = 5'sd0;
  localparam logic signed [GEAR_W-1:0] GEAR_FIRST   = 5'sd1;

  // Thresholds (Q8.8 speed, Q12.4 engine speed, Q3.12 angle, Q8.8 distance)
  localparam logic [WORD_W-1:0]         SPEED_SLOW  = 16'd256;   // 1 m/s
  localparam logic [WORD_W-1:0]         SPEED_FAST  = 16'd3840;  // 15 m/s
  localparam logic [WORD_W-1:0]         ENG_REV_HOT = 16'd8000;  // 500 rad/s
  localparam logic [WORD_W-1:0]         DOWN_OFS    = 16'd2080;  // 130 rad/s
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIM   = 15'sd4096; // 1 rad
  localparam logic signed [WORD_W-1:0]  BORDER_LIM  = -16'sd512; // -2 m

  // Exact ratio tests: e/r > 0.98 and e/r > 0.7
  localparam logic [5:0] UP_NUM  = 6'd50;
  localparam logic [5:0] UP_DEN  = 6'd49;
  localparam logic [3:0] HOT_NUM = 4'd10;
  localparam logic [3:0] HOT_DEN = 4'd7;

  // Clutch levels, Q1.16
  localparam logic [CLUTCH_W-1:0] CL_STEP     = 17'd2621;
  localparam logic [CLUTCH_W-1:0] CL_STEP_REV = 17'd655;
  localparam logic [CLUTCH_W-1:0] CL_UPSHIFT  = 17'd19661;
  localparam logic [CLUTCH_W-1:0] CL_START    = 17'd45875;
  localparam logic [CLUTCH_W-1:0] CL_ONE      = 17'd65536;

  // Per-item decisions that need no state, computed ahead of the state logic
  typedef struct packed {
    logic slow;      // below 1 m/s: no shift wait
    logic fast;      // above 15 m/s
    logic up;        // engine above 98 % of redline
    logic down;      // lower gear keeps engine below redline - 130 rad/s
    logic hot;       // engine above 70 % of redline
    logic rev_hot;   // engine above 500 rad/s
    logic off_track; // heading or border far off
  } flags_t;

endpackage

// ===== src/gear_shift_and_clutch_control_unit.sv =====
// Top level: gear command and clutch level, one control tick per transaction.
// Depends on gscc_pkg and gscc_cmp.
//
//  channel  | direction | contents
//  s_*      | in        | one control tick (gear, speeds, ratios, reverse, course)
//  m_*      | out       | commanded gear and clutch level
//  cfg_*    | in        | register writes: redline_speed, top_gear
//
// One transaction per cycle sustained while m_tready is high; each tick passes through
// the compare register, then the result register that also updates the shift
// timer, clutch and last gear; back-to-back ticks thus see the prior update.
// m_tready low holds the result register; the compare register still fills, then
// s_tready drops. Reset (rst, synchronous) empties both stages and clears state.
module gear_shift_and_clutch_control_unit #(
  parameter int SHIFT_DELAY = gscc_pkg::SHIFT_DELAY_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // current_gear[4:0], car_speed[20:5], engine_speed[36:21], ratio_now[52:37],
  // ratio_below[68:53], reverse_request[69], track_angle[84:70],
  // border_distance[100:85], zero fill[103:101]
  input  logic [103:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // gear_command[4:0], clutch_level[21:5], zero fill[23:22]
  output logic [23:0]  m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int WAIT_W = $clog2(SHIFT_DELAY + 1);
  localparam logic [WAIT_W-1:0] DELAY = WAIT_W'(SHIFT_DELAY);

  // Configuration
  logic [15:0] redline_speed;
  logic [3:0]  top_gear;

  // Unpacked input fields
  logic signed [4:0]  in_gear;
  logic signed [14:0] in_angle;
  logic signed [15:0] in_border;
  gscc_pkg::flags_t   in_flags;

  // Compare register
  logic               s1_valid;
  logic signed [4:0]  s1_gear;
  logic               s1_rev;
  gscc_pkg::flags_t   s1_flags;

  // State
  logic [WAIT_W-1:0]  shift_wait, shift_wait_next;
  logic [16:0]        clutch_value, clutch_value_next;
  logic signed [4:0]  last_gear;

  // Result register
  logic               out_valid;
  logic signed [4:0]  gear_cmd, gear_cmd_next;

  logic               adv;
  logic [WAIT_W-1:0]  limit, wait_inc;
  logic signed [18:0] cl_base, cl_sum;

  assign in_gear   = s_tdata[4:0];
  assign in_angle  = s_tdata[84:70];
  assign in_border = s_tdata[100:85];

  gscc_cmp u_cmp (
    .car_speed       (s_tdata[20:5]),
    .engine_speed    (s_tdata[36:21]),
    .ratio_now       (s_tdata[52:37]),
    .ratio_below     (s_tdata[68:53]),
    .track_angle     (in_angle),
    .border_distance (in_border),
    .redline_speed   (redline_speed),
    .flags           (in_flags)
  );

  // Handshake: stage 1 moves when the result register is free or drains
  assign adv      = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || adv;
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, clutch_value, gear_cmd};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      redline_speed <= gscc_pkg::REDLINE_RESET;
      top_gear      <= gscc_pkg::TOP_GEAR_RESET;
    end else if (cfg_we) begin
      unique case (gscc_pkg::cfg_reg_t'(cfg_index))
        gscc_pkg::REG_REDLINE:  redline_speed <= cfg_data;
        gscc_pkg::REG_TOP_GEAR: top_gear      <= cfg_data[3:0];
        default:                ;
      endcase
    end
  end

  // Compare register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_gear  <= in_gear;
      s1_rev   <= s_tdata[69];
      s1_flags <= in_flags;
    end
  end

  // Gear command and shift timer
  always_comb begin
    limit           = s1_flags.slow ? '0 : DELAY;
    wait_inc        = (shift_wait < limit) ? shift_wait + 1'b1 : shift_wait;
    shift_wait_next = wait_inc;
    if (wait_inc < limit) begin
      gear_cmd_next = s1_gear;
    end else if (s1_rev) begin
      gear_cmd_next = gscc_pkg::GEAR_REV;
    end else if (s1_gear <= gscc_pkg::GEAR_NEUTRAL) begin
      gear_cmd_next = gscc_pkg::GEAR_FIRST;
    end else if ((s1_gear[3:0] < top_gear) && s1_flags.up) begin
      shift_wait_next = '0;
      gear_cmd_next   = s1_gear + 5'sd1;
    end else if ((s1_gear > gscc_pkg::GEAR_FIRST) && s1_flags.down) begin
      shift_wait_next = '0;
      gear_cmd_next   = s1_gear - 5'sd1;
    end else begin
      gear_cmd_next = s1_gear;
    end
  end

  // Clutch ramp, clipped to 0..1
  always_comb begin
    cl_base = $signed({2'b00, clutch_value});
    cl_sum  = cl_base;
    if ((s1_gear > gscc_pkg::GEAR_FIRST) || s1_flags.fast) begin
      if (s1_gear > last_gear) cl_base = $signed({2'b00, gscc_pkg::CL_UPSHIFT});
      cl_sum = s1_flags.hot ? cl_base - $signed({2'b00, gscc_pkg::CL_STEP})
                            : cl_base + $signed({2'b00, gscc_pkg::CL_STEP});
      if (s1_gear < last_gear) cl_sum = '0;
    end else if (s1_gear == gscc_pkg::GEAR_FIRST) begin
      cl_sum = s1_flags.hot ? cl_base - $signed({2'b00, gscc_pkg::CL_STEP})
                            : cl_base + $signed({2'b00, gscc_pkg::CL_STEP});
      if (s1_flags.off_track) cl_sum = '0;
    end else if (s1_gear == gscc_pkg::GEAR_NEUTRAL) begin
      cl_sum = $signed({2'b00, gscc_pkg::CL_START});
    end else if (s1_gear == gscc_pkg::GEAR_REV) begin
      cl_sum = s1_flags.rev_hot ? cl_base - $signed({2'b00, gscc_pkg::CL_STEP_REV})
                                : cl_base + $signed({2'b00, gscc_pkg::CL_STEP_REV});
    end
    if (cl_sum < 0) begin
      clutch_value_next = '0;
    end else if (cl_sum > $signed({2'b00, gscc_pkg::CL_ONE})) begin
      clutch_value_next = gscc_pkg::CL_ONE;
    end else begin
      clutch_value_next = cl_sum[16:0];
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_wait   <= '0;
      clutch_value <= '0;
      last_gear    <= gscc_pkg::GEAR_NEUTRAL;
      out_valid    <= 1'b0;
    end else begin
      if (adv) begin
        shift_wait   <= shift_wait_next;
        clutch_value <= clutch_value_next;
        last_gear    <= s1_gear;
        out_valid    <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) gear_cmd <= gear_cmd_next;
  end

  // Checks
  a_clutch_range: assert property (@(posedge clk) disable iff (rst)
    clutch_value <= gscc_pkg::CL_ONE)
    else $error("clutch level above full release");

  a_wait_range: assert property (@(posedge clk) disable iff (rst)
    shift_wait <= DELAY)
    else $error("shift timer past its delay");

  a_last_gear: assert property (@(posedge clk) disable iff (rst)
    adv |=> (last_gear == $past(s1_gear)))
    else $error("last gear not taken from the finished tick");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("finished tick did not reach the result register");

endmodule

// ===== src/gscc_cmp.sv =====
// Stateless compare stage: ratio cross-multiplications and threshold tests.
// Depends on gscc_pkg.
module gscc_cmp (
  input  logic [15:0]        car_speed,
  input  logic [15:0]        engine_speed,
  input  logic [15:0]        ratio_now,
  input  logic [15:0]        ratio_below,
  input  logic signed [14:0] track_angle,
  input  logic signed [15:0] border_distance,
  input  logic [15:0]        redline_speed,
  output gscc_pkg::flags_t   flags
);

  logic [21:0] up_eng, up_red;
  logic [19:0] hot_eng, hot_red;
  logic [15:0] red_ofs;
  logic [31:0] down_red, down_eng;

  // Upshift and clutch tests, exact by cross-multiplication
  assign up_eng  = 22'(engine_speed) * 22'(gscc_pkg::UP_NUM);
  assign up_red  = 22'(redline_speed) * 22'(gscc_pkg::UP_DEN);
  assign hot_eng = 20'(engine_speed) * 20'(gscc_pkg::HOT_NUM);
  assign hot_red = 20'(redline_speed) * 20'(gscc_pkg::HOT_DEN);

  // Downshift: (red - 130) * r_now > r_below * eng, false at low redline
  assign red_ofs  = redline_speed - gscc_pkg::DOWN_OFS;
  assign down_red = 32'(red_ofs) * 32'(ratio_now);
  assign down_eng = 32'(ratio_below) * 32'(engine_speed);

  always_comb begin
    flags.slow      = car_speed < gscc_pkg::SPEED_SLOW;
    flags.fast      = car_speed > gscc_pkg::SPEED_FAST;
    flags.up        = up_eng > up_red;
    flags.down      = (redline_speed > gscc_pkg::DOWN_OFS) && (down_red > down_eng);
    flags.hot       = hot_eng > hot_red;
    flags.rev_hot   = engine_speed > gscc_pkg::ENG_REV_HOT;
    flags.off_track = (track_angle > gscc_pkg::ANGLE_LIM) ||
                      (track_angle < -gscc_pkg::ANGLE_LIM) ||
                      (border_distance < gscc_pkg::BORDER_LIM);
  end

endmodule
